// ----- rtl/core/kelpd_pkg.sv -----
// ----------------------------------------------------------------------------
// kelpd_pkg
// Shared constants, phase and event codes and the per-key control bundle
// for the key press / release / long-press detector.
// ----------------------------------------------------------------------------
package kelpd_pkg;

  // Default number of keys, and keys that own a bit in the tick's pin levels
  localparam int KEY_COUNT_DEF = 5;
  localparam int PIN_COUNT     = 5;

  localparam int HOLD_W   = 16;
  localparam int NUMBER_W = 3;
  localparam int EVENT_W  = 2;
  localparam int PHASE_W  = 2;

  localparam logic [HOLD_W-1:0] LONG_TICKS_RESET = 16'd1500;
  localparam logic [HOLD_W-1:0] HOLD_MAX         = '1;

  // Request kind carried in tuser
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Key phases
  localparam logic [PHASE_W-1:0] PH_IDLE     = 2'd0;
  localparam logic [PHASE_W-1:0] PH_PRESSED  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_LONGED   = 2'd2;
  localparam logic [PHASE_W-1:0] PH_RELEASED = 2'd3;

  // Pending event codes
  localparam logic [EVENT_W-1:0] EV_NONE = 2'd0;
  localparam logic [EVENT_W-1:0] EV_DOWN = 2'd1;
  localparam logic [EVENT_W-1:0] EV_UP   = 2'd2;
  localparam logic [EVENT_W-1:0] EV_LONG = 2'd3;

  // Control for one key channel in the cycle a request is processed
  typedef struct packed {
    logic tick;   // advance the phase machine with the sampled level
    logic down;   // key reads pressed on this tick
    logic clear;  // query matched, drop the pending event
  } key_ctrl_t;

endpackage

// ----- rtl/core/key_event_long_press_detector_unit.sv -----
// ----------------------------------------------------------------------------
// key_event_long_press_detector_unit
// Press / release / long-press event detector for a row of active-low keys.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries requests. tuser = 0 is a one-millisecond tick whose
//   tdata[4:0] holds the sampled key levels (0 = pressed); tuser = 1 is a
//   query with key number in tdata[7:5] and event kind in tdata[9:8].
//   m_axis returns one response per request: tdata[0] is 1 when a query hit
//   the key's pending event (which is then consumed), 0 for ticks and misses.
//   cfg_we_i / cfg_wdata_i load the long-press limit while nothing is in flight.
// Timing:
//   A request is latched in an input register, evaluated against all keys in
//   parallel and its response lands in the output register once that register
//   can take it. One request per cycle is sustained while m_axis_tready is high.
// Reset and stalls:
//   Reset puts every key idle with no event pending and the limit at 1500.
//   While m_axis_tready is low the response holds; one more request is still
//   taken into the input register before s_axis_tready drops.
// ----------------------------------------------------------------------------
module key_event_long_press_detector_unit #(
  parameter int KEY_COUNT = kelpd_pkg::KEY_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: long-press limit
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // pin_levels[4:0], key_number[7:5],
                                     // event_kind[9:8], zero [15:10]
  input  logic [0:0]  s_axis_tuser,  // action[0]
  // Response stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // event_found[0], zero [7:1]
);

  typedef struct packed {
    logic                               action;
    logic [kelpd_pkg::PIN_COUNT-1:0]    pin_levels;
    logic [kelpd_pkg::NUMBER_W-1:0]     key_number;
    logic [kelpd_pkg::EVENT_W-1:0]      event_kind;
  } req_t;

  logic [kelpd_pkg::HOLD_W-1:0] limit_q;

  logic in_valid_q;
  req_t in_q;
  logic out_valid_q;
  logic found_q, found_d;
  logic advance;

  logic [KEY_COUNT-1:0] match;
  logic [kelpd_pkg::EVENT_W-1:0] pending [KEY_COUNT];

  // Process the held request when the output register can take its response
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= kelpd_pkg::LONG_TICKS_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.action     <= s_axis_tuser[0];
      in_q.pin_levels <= s_axis_tdata[4:0];
      in_q.key_number <= s_axis_tdata[7:5];
      in_q.event_kind <= s_axis_tdata[9:8];
    end
  end

  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
    kelpd_pkg::key_ctrl_t ctrl;
    logic down;
    logic hit;

    if (k < kelpd_pkg::PIN_COUNT) begin : g_pin
      assign down = ~in_q.pin_levels[k];
    end else begin : g_no_pin
      assign down = 1'b0;
    end

    assign hit      = (32'(in_q.key_number) == k + 1);
    assign match[k] = (in_q.action == kelpd_pkg::ACT_QUERY) && hit &&
                      (pending[k] == in_q.event_kind);

    assign ctrl.tick  = advance && (in_q.action == kelpd_pkg::ACT_TICK);
    assign ctrl.down  = down;
    assign ctrl.clear = advance && match[k];

    kelpd_key u_key (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .limit_i   (limit_q),
      .pending_o (pending[k])
    );
  end

  assign found_d = |match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      found_q <= found_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, found_q};

endmodule

// ----- rtl/core/kelpd_key.sv -----
// ----------------------------------------------------------------------------
// kelpd_key
// One key channel: phase machine, saturating hold counter and the single
// pending event slot.
// ----------------------------------------------------------------------------
module kelpd_key (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  kelpd_pkg::key_ctrl_t                ctrl_i,
  input  logic [kelpd_pkg::HOLD_W-1:0]        limit_i,
  output logic [kelpd_pkg::EVENT_W-1:0]       pending_o
);

  logic [kelpd_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [kelpd_pkg::HOLD_W-1:0]  hold_q, hold_d, hold_inc;
  logic [kelpd_pkg::EVENT_W-1:0] pending_q, pending_d;

  assign hold_inc = (hold_q == kelpd_pkg::HOLD_MAX) ? hold_q
                                                    : hold_q + 1'b1;

  always_comb begin
    phase_d   = phase_q;
    hold_d    = hold_q;
    pending_d = pending_q;
    if (ctrl_i.tick) begin
      unique case (phase_q)
        kelpd_pkg::PH_IDLE: begin
          if (ctrl_i.down) begin
            phase_d   = kelpd_pkg::PH_PRESSED;
            hold_d    = '0;
            pending_d = kelpd_pkg::EV_DOWN;
          end
        end
        kelpd_pkg::PH_PRESSED: begin
          if (!ctrl_i.down) begin
            phase_d   = kelpd_pkg::PH_RELEASED;
            pending_d = kelpd_pkg::EV_UP;
          end else begin
            hold_d = hold_inc;
            // compare against the counter after this tick's increment
            if (hold_inc >= limit_i) begin
              phase_d   = kelpd_pkg::PH_LONGED;
              pending_d = kelpd_pkg::EV_LONG;
            end
          end
        end
        kelpd_pkg::PH_LONGED: begin
          if (!ctrl_i.down) begin
            phase_d   = kelpd_pkg::PH_RELEASED;
            pending_d = kelpd_pkg::EV_UP;
          end
        end
        kelpd_pkg::PH_RELEASED: begin
          if (!ctrl_i.down) begin
            phase_d = kelpd_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_d = kelpd_pkg::PH_IDLE;
        end
      endcase
    end else if (ctrl_i.clear) begin
      pending_d = kelpd_pkg::EV_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= kelpd_pkg::PH_IDLE;
      hold_q    <= '0;
      pending_q <= kelpd_pkg::EV_NONE;
    end else begin
      phase_q   <= phase_d;
      hold_q    <= hold_d;
      pending_q <= pending_d;
    end
  end

  assign pending_o = pending_q;

endmodule

// ----- rtl/core/kelpd_checker.sv -----
// ----------------------------------------------------------------------------
// kelpd_checker
// Port-level checks for the key event detector, bound to the top level.
// ----------------------------------------------------------------------------
module kelpd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // No response may survive reset
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("response valid during reset");

  // An empty output register always frees the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("request stalled with empty output");

  // Only the match flag may ever be set in a response
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'd0))
    else $error("response padding not zero");

  // Hold a stalled response
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled response changed");

endmodule

bind key_event_long_press_detector_unit kelpd_checker u_kelpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
